>>> hw/rtl/hcbd_pkg.sv
// Package for the chunked body decoder: phase encoding, size width,
// byte codes and the hex digit decode. No dependencies.
package hcbd_pkg;

    localparam int SIZE_BITS = 32;

    typedef logic [SIZE_BITS-1:0] t_size;

    typedef enum logic [2:0] {
        PH_SIZE   = 3'd0,
        PH_SIZECR = 3'd1,
        PH_DATA   = 3'd2,
        PH_TRL1   = 3'd3,
        PH_TRL2   = 3'd4,
        PH_ENDCR  = 3'd5,
        PH_ENDLF  = 3'd6
    } t_phase;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // ASCII hex digit, either case
    function automatic t_hex hex_decode(input logic [7:0] b);
        t_hex h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.ok  = 1'b1;
            h.val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.ok  = 1'b1;
            h.val = 4'(b - 8'h37);
        end
        return h;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
    endfunction

endpackage

>>> hw/rtl/http_chunked_body_decoder.sv
// Chunked transfer body decoder, top level.
// Depends on hcbd_pkg for phase encoding, size width and hex decode.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | i_valid / o_ready  | i_in_byte
//  out     | o_valid / i_ready  | o_payload_byte, o_payload_valid,
//          |                    | o_chunk_last, o_message_end, o_format_error
//
// One item in, one item out. Two register stages: an input register and a
// result register, with the decode step between them; sustained rate is one
// item per cycle while the output is not stalled.
// Synchronous active-low reset clears the valid flags of both stages, the
// phase, the size counter, the digit flags and the sticky error flag.
// A stalled output holds the result register; the input register then holds
// its item and o_ready drops until the result is taken.
module http_chunked_body_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_payload_valid,
    output logic       o_chunk_last,
    output logic       o_message_end,
    output logic       o_format_error
);

    // input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // decoder state
    hcbd_pkg::t_phase r_phase,  n_phase;
    hcbd_pkg::t_size  r_remaining, n_remaining;
    logic             r_digits_closed, n_digits_closed;
    logic             r_saw_digit, n_saw_digit;
    logic             r_err, n_err;

    // result stage
    logic       r_out_valid;
    logic [7:0] r_payload_byte;
    logic       r_payload_valid, r_chunk_last, r_message_end, r_format_error;

    // combinational results of the step
    logic [7:0] c_pbyte;
    logic       c_pvalid, c_plast, c_mend;

    logic          step;    // item moves from input to result register
    hcbd_pkg::t_hex hx;
    hcbd_pkg::t_size dec;

    assign step    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || step;

    assign hx  = hcbd_pkg::hex_decode(r_in_byte);
    assign dec = r_remaining - hcbd_pkg::t_size'(1);

    // next state
    always_comb begin
        n_phase         = r_phase;
        n_remaining     = r_remaining;
        n_digits_closed = r_digits_closed;
        n_saw_digit     = r_saw_digit;
        n_err           = r_err;
        unique case (r_phase)
            hcbd_pkg::PH_SIZECR: begin
                if (r_in_byte == hcbd_pkg::CH_LF) begin
                    if (r_saw_digit && (r_remaining != '0)) begin
                        n_phase = hcbd_pkg::PH_DATA;
                    end else begin
                        n_phase = hcbd_pkg::PH_ENDCR;
                    end
                end else if (r_in_byte != hcbd_pkg::CH_CR) begin
                    // lone CR: line goes on, digits already closed
                    n_phase = hcbd_pkg::PH_SIZE;
                end
            end
            hcbd_pkg::PH_DATA: begin
                n_remaining = dec;
                if (dec == '0) begin
                    n_phase = hcbd_pkg::PH_TRL1;
                end
            end
            hcbd_pkg::PH_TRL1: begin
                n_phase = hcbd_pkg::PH_TRL2;
            end
            hcbd_pkg::PH_TRL2: begin
                n_phase         = hcbd_pkg::PH_SIZE;
                n_remaining     = '0;
                n_digits_closed = 1'b0;
                n_saw_digit     = 1'b0;
            end
            hcbd_pkg::PH_ENDCR: begin
                if (r_in_byte == hcbd_pkg::CH_CR) begin
                    n_phase = hcbd_pkg::PH_ENDLF;
                end else begin
                    n_err           = 1'b1;
                    n_phase         = hcbd_pkg::PH_SIZE;
                    n_remaining     = '0;
                    n_digits_closed = 1'b0;
                    n_saw_digit     = 1'b0;
                end
            end
            hcbd_pkg::PH_ENDLF: begin
                if (r_in_byte != hcbd_pkg::CH_LF) begin
                    n_err = 1'b1;
                end
                n_phase         = hcbd_pkg::PH_SIZE;
                n_remaining     = '0;
                n_digits_closed = 1'b0;
                n_saw_digit     = 1'b0;
            end
            default: begin
                // size line (and any unused code)
                n_phase = hcbd_pkg::PH_SIZE;
                priority if (r_in_byte == hcbd_pkg::CH_CR) begin
                    n_digits_closed = 1'b1;
                    n_phase         = hcbd_pkg::PH_SIZECR;
                end else if (r_digits_closed) begin
                    n_digits_closed = 1'b1;
                end else if (!hx.ok) begin
                    // leading blanks skipped, anything else ends the digits
                    if (r_saw_digit || !hcbd_pkg::is_blank(r_in_byte)) begin
                        n_digits_closed = 1'b1;
                    end
                end else if (r_remaining[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
                    // overflow: drop digit, keep size so far
                    n_err           = 1'b1;
                    n_digits_closed = 1'b1;
                end else begin
                    n_remaining = {r_remaining[hcbd_pkg::SIZE_BITS-5:0], hx.val};
                    n_saw_digit = 1'b1;
                end
            end
        endcase
    end

    // step outputs
    always_comb begin
        c_pvalid = 1'b0;
        c_plast  = 1'b0;
        c_mend   = 1'b0;
        c_pbyte  = 8'd0;
        unique case (r_phase)
            hcbd_pkg::PH_DATA: begin
                c_pvalid = 1'b1;
                c_pbyte  = r_in_byte;
                c_plast  = (dec == '0);
            end
            hcbd_pkg::PH_ENDLF: begin
                c_mend = (r_in_byte == hcbd_pkg::CH_LF);
            end
            default: begin
                c_pvalid = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_phase         <= hcbd_pkg::PH_SIZE;
            r_remaining     <= '0;
            r_digits_closed <= 1'b0;
            r_saw_digit     <= 1'b0;
            r_err           <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (step) begin
                r_out_valid     <= 1'b1;
                r_phase         <= n_phase;
                r_remaining     <= n_remaining;
                r_digits_closed <= n_digits_closed;
                r_saw_digit     <= n_saw_digit;
                r_err           <= n_err;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_in_byte;
        end
        if (step) begin
            r_payload_byte  <= c_pbyte;
            r_payload_valid <= c_pvalid;
            r_chunk_last    <= c_plast;
            r_message_end   <= c_mend;
            r_format_error  <= n_err;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_payload_byte  = r_payload_byte;
    assign o_payload_valid = r_payload_valid;
    assign o_chunk_last    = r_chunk_last;
    assign o_message_end   = r_message_end;
    assign o_format_error  = r_format_error;

endmodule

>>> tb/http_chunked_body_decoder_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for http_chunked_body_decoder: directed and random chunked bodies.
// Depends on hcbd_pkg for the phase encoding, size width and byte codes.
module http_chunked_body_decoder_tb;

    localparam int STALL_LIMIT = 1000;   // cycles with no handshake before giving up
    localparam int RANDOM_ITEMS = 1000;

    // one decoded result item, as the block presents it
    typedef struct packed {
        logic [7:0] data;
        logic       data_valid;
        logic       last;
        logic       msg_end;
        logic       error;
    } t_decoded;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_in_byte = 8'h00;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_payload_byte;
    logic       o_payload_valid;
    logic       o_chunk_last;
    logic       o_message_end;
    logic       o_format_error;

    // decoder state as the testbench tracks it
    hcbd_pkg::t_phase ph = hcbd_pkg::PH_SIZE;
    hcbd_pkg::t_size  left = '0;
    logic       closed = 1'b0;
    logic       got_digit = 1'b0;
    logic       err_seen = 1'b0;

    t_decoded   decoded_q[$];
    int         fails = 0;
    int         bytes_sent = 0;
    int         idle_cycles = 0;
    logic       idle_on = 1'b0;

    http_chunked_body_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_byte      (i_in_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_payload_byte (o_payload_byte),
        .o_payload_valid(o_payload_valid),
        .o_chunk_last   (o_chunk_last),
        .o_message_end  (o_message_end),
        .o_format_error (o_format_error)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Byte decode predictor
    // ------------------------------------------------------------------

    // value of an ASCII hex digit, -1 for anything else
    function automatic int hex_of(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b) - int'("0");
        if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
        if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
        return -1;
    endfunction

    function void line_restart();
        ph        = hcbd_pkg::PH_SIZE;
        left      = '0;
        closed    = 1'b0;
        got_digit = 1'b0;
    endfunction

    // advance the tracked state by one accepted byte and queue the expected item
    function void predict_byte(input logic [7:0] b);
        t_decoded r;
        int       nib;
        r = '0;
        case (ph)
            hcbd_pkg::PH_SIZECR: begin
                // only LF ends the line; another CR keeps waiting, anything else reopens it
                if (b == hcbd_pkg::CH_LF) begin
                    ph = (got_digit && left != '0) ? hcbd_pkg::PH_DATA : hcbd_pkg::PH_ENDCR;
                end else if (b != hcbd_pkg::CH_CR) begin
                    ph = hcbd_pkg::PH_SIZE;
                end
            end
            hcbd_pkg::PH_DATA: begin
                r.data       = b;
                r.data_valid = 1'b1;
                left         = left - 1'b1;
                if (left == '0) begin
                    r.last = 1'b1;
                    ph     = hcbd_pkg::PH_TRL1;
                end
            end
            hcbd_pkg::PH_TRL1: ph = hcbd_pkg::PH_TRL2;
            hcbd_pkg::PH_TRL2: line_restart();
            hcbd_pkg::PH_ENDCR: begin
                if (b == hcbd_pkg::CH_CR) begin
                    ph = hcbd_pkg::PH_ENDLF;
                end else begin
                    err_seen = 1'b1;
                    line_restart();
                end
            end
            hcbd_pkg::PH_ENDLF: begin
                if (b == hcbd_pkg::CH_LF) r.msg_end = 1'b1;
                else err_seen = 1'b1;
                line_restart();
            end
            default: begin
                ph = hcbd_pkg::PH_SIZE;
                if (b == hcbd_pkg::CH_CR) begin
                    closed = 1'b1;
                    ph     = hcbd_pkg::PH_SIZECR;
                end else if (!closed) begin
                    nib = hex_of(b);
                    if (nib < 0) begin
                        // blanks are skipped only ahead of the first digit
                        if (got_digit || !(b inside {hcbd_pkg::CH_SP, hcbd_pkg::CH_TAB,
                                                     hcbd_pkg::CH_VT, hcbd_pkg::CH_FF}))
                            closed = 1'b1;
                    end else if (left[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
                        // next digit would overflow: drop it, keep the size so far
                        err_seen = 1'b1;
                        closed   = 1'b1;
                    end else begin
                        left      = {left[hcbd_pkg::SIZE_BITS-5:0], 4'(nib)};
                        got_digit = 1'b1;
                    end
                end
            end
        endcase
        r.error = err_seen;
        decoded_q.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Present one byte and hold it until the block takes it. A random gap may
    // come first; valid is only dropped when a gap is actually inserted.
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(99) < 33) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_crlf();
        send_byte(hcbd_pkg::CH_CR);
        send_byte(hcbd_pkg::CH_LF);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0: return hcbd_pkg::CH_SP;
            1: return hcbd_pkg::CH_TAB;
            2: return hcbd_pkg::CH_VT;
            default: return hcbd_pkg::CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] pick_non_hex();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (hex_of(b) >= 0);
        return b;
    endfunction

    // Size line for sz, dressed at random: leading blanks and zeros, mixed case,
    // an extension, a lone CR inside the line, a doubled CR before LF.
    // For sz == 0 the digits may be left out altogether.
    task automatic send_size_line(input int unsigned sz);
        string      hs;
        logic [7:0] c;
        int         i;
        int         tail;
        repeat ($urandom_range(0, 2)) send_byte(pick_blank());
        if (sz != 0 || $urandom_range(2) != 0) begin
            repeat ($urandom_range(0, 2)) send_byte("0");
            hs = $sformatf("%x", sz);
            // drop the zero padding that %x adds
            while (hs.len() > 1 && hs[0] == "0") hs = hs.substr(1, hs.len() - 1);
            for (i = 0; i < hs.len(); i++) begin
                c = hs[i];
                if (c >= "a" && c <= "f" && $urandom_range(1)) c = c - 8'h20;
                send_byte(c);
            end
        end
        tail = $urandom_range(3);
        if (tail[0]) begin
            // extension: starts with a closer, then anything but CR
            if ($urandom_range(1)) send_byte(pick_blank());
            send_byte(";");
            repeat ($urandom_range(0, 4)) begin
                do c = 8'($urandom_range(255)); while (c == hcbd_pkg::CH_CR);
                send_byte(c);
            end
        end
        if (tail[1]) begin
            // lone CR: the line goes on
            send_byte(hcbd_pkg::CH_CR);
            do c = 8'($urandom_range(255));
            while (c == hcbd_pkg::CH_CR || c == hcbd_pkg::CH_LF);
            send_byte(c);
        end
        if ($urandom_range(4) == 0) send_byte(hcbd_pkg::CH_CR);
        send_crlf();
    endtask

    // One message the block decodes without error: a few chunks, then the zero chunk and empty line.
    task automatic send_message();
        int unsigned sz;
        repeat ($urandom_range(0, 4)) begin
            sz = ($urandom_range(9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 12);
            send_size_line(sz);
            repeat (sz) send_byte(8'($urandom_range(255)));
            // trailer is not checked by the block
            if ($urandom_range(4) == 0) begin
                send_byte(8'($urandom_range(255)));
                send_byte(8'($urandom_range(255)));
            end else begin
                send_crlf();
            end
        end
        send_size_line(0);
        send_crlf();
    endtask

    // Drive the decoder back to a clean line start, whatever phase it is in.
    task automatic resync();
        while (!(ph == hcbd_pkg::PH_SIZE && !closed && !got_digit)) begin
            case (ph)
                hcbd_pkg::PH_SIZE, hcbd_pkg::PH_ENDCR:   send_byte(hcbd_pkg::CH_CR);
                hcbd_pkg::PH_SIZECR, hcbd_pkg::PH_ENDLF: send_byte(hcbd_pkg::CH_LF);
                default:                                 send_byte(8'($urandom_range(255)));
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // tab skipped, blank closes the digits, extension, payload extremes,
    // trailer bytes that are not CRLF
    task automatic test_chunk_data();
        send_byte(hcbd_pkg::CH_TAB);
        send_text("2 f;x");
        send_crlf();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("zz");
    endtask

    // lone CR inside the size line, then a repeated CR before LF
    task automatic test_line_quirks();
        send_text("1");
        send_byte(hcbd_pkg::CH_CR);
        send_text("Q");
        send_byte(hcbd_pkg::CH_CR);
        send_crlf();
        send_byte(8'h5A);
        send_crlf();
    endtask

    // zero chunk, and a size line with no digits at all
    task automatic test_message_end();
        send_text("0");
        send_crlf();
        send_crlf();
        send_text(" ;e");
        send_crlf();
        send_crlf();
    endtask

    // wrong byte where the empty line's CR, then its LF, is due
    task automatic test_bad_terminator();
        send_text("0");
        send_crlf();
        send_text("X");
        send_text("0");
        send_crlf();
        send_byte(hcbd_pkg::CH_CR);
        send_text("X");
    endtask

    // mostly well-formed messages; the rest is noise and bad terminators
    task automatic test_random_messages();
        int first;
        int n;
        first = bytes_sent;
        n     = 0;
        while (n < RANDOM_ITEMS) begin
            // a long stretch in the middle runs without any idling
            idle_on <= !(n >= 400 && n < 650);
            case ($urandom_range(19))
                0, 1: begin
                    repeat ($urandom_range(1, 6)) send_byte(pick_non_hex());
                    resync();
                end
                2: begin
                    send_size_line(0);
                    if ($urandom_range(1)) send_byte(hcbd_pkg::CH_CR);
                    send_byte(pick_non_hex());
                    resync();
                end
                default: send_message();
            endcase
            n = bytes_sent - first;
        end
        idle_on <= 1'b1;
    endtask

    // Size overflow runs last: the size gathered before the dropped digit is
    // already 2^28 or more, so the decoder stays in the payload from here on.
    task automatic test_size_overflow();
        send_text("100000000");
        send_crlf();
        repeat (4) send_byte(8'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure and the result check
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        i_ready <= !(idle_on && $urandom_range(99) < 33);
    end

    task automatic cmp_field(input string fname, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, fname, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_decoded e;
        if (i_rst_n && o_valid && i_ready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected item: byte %0h valid %0b last %0b end %0b err %0b",
                         $time, o_payload_byte, o_payload_valid, o_chunk_last,
                         o_message_end, o_format_error);
                fails++;
            end else begin
                e = decoded_q.pop_front();
                cmp_field("payload_byte", e.data, o_payload_byte);
                cmp_field("payload_valid", 8'(e.data_valid), 8'(o_payload_valid));
                cmp_field("chunk_last", 8'(e.last), 8'(o_chunk_last));
                cmp_field("message_end", 8'(e.msg_end), 8'(o_message_end));
                cmp_field("format_error", 8'(e.error), 8'(o_format_error));
            end
        end
    end

    // watchdog: any handshake on either side restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d items outstanding",
                     $time, idle_cycles, decoded_q.size());
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on <= 1'b1;
        @(posedge i_clk);

        test_chunk_data();
        test_line_quirks();
        test_message_end();
        test_bad_terminator();
        test_random_messages();
        test_size_overflow();

        i_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        // two-stage pipe: give a stray extra item time to show up
        repeat (8) @(posedge i_clk);
        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
